// ===== rtl/nps_pkg.sv =====
// Package with the shared types, field widths and state codes of the priority scheduler.
package nps_pkg;

  // Field widths of the input and result transactions.
  localparam int ArrW  = 16;
  localparam int BurW  = 16;
  localparam int PriW  = 8;
  localparam int PnW   = 5;
  localparam int TimeW = 21;
  localparam int SumW  = 25;

  // One stored process as it sits in the process memory.
  typedef struct packed {
    logic [ArrW-1:0] arrival;
    logic [BurW-1:0] burst;
    logic [PriW-1:0] prio;
  } entry_t;

  // Status of one selection scan, passed from the selector to the sequencer.
  typedef struct packed {
    logic   ready_found;
    entry_t ready;
    entry_t fallback;
  } pick_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_LOAD,
    S_SCAN,
    S_CLK,
    S_TURN,
    S_WAIT,
    S_SUM,
    S_OUT
  } state_t;

endpackage

// ===== rtl/nps_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
module nps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/nps_select.sv =====
// Running best-candidate tracker fed with one memory entry per cycle during a scan.
module nps_select #(
  parameter int MAX_PROCS = 16
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      start,
  input  logic                                      cmp_vld,
  input  logic [(MAX_PROCS > 1 ? $clog2(MAX_PROCS) : 1)-1:0] cmp_idx,
  input  nps_pkg::entry_t                           cmp_ent,
  input  logic                                      cmp_done,
  input  logic [nps_pkg::TimeW-1:0]                 clock,
  output nps_pkg::pick_t                            pick,
  output logic [(MAX_PROCS > 1 ? $clog2(MAX_PROCS) : 1)-1:0] ready_idx,
  output logic [(MAX_PROCS > 1 ? $clog2(MAX_PROCS) : 1)-1:0] fb_idx
);
  import nps_pkg::*;

  logic   ready_found;
  logic   fb_found;
  logic   is_ready;
  logic   ready_better;
  logic   fb_better;
  entry_t ready_ent;
  entry_t fb_ent;

  // An entry is ready when it is pending and has arrived by the current clock.
  // Entries come in ascending index order, so strict compares keep the lower index on ties.
  always_comb begin
    is_ready = !cmp_done && ({{(TimeW - ArrW){1'b0}}, cmp_ent.arrival} <= clock);
    ready_better = !ready_found || (cmp_ent.prio < ready_ent.prio) ||
                   ((cmp_ent.prio == ready_ent.prio) && (cmp_ent.arrival < ready_ent.arrival));
    // The fallback is what would run after the clock jumps to the earliest pending arrival.
    fb_better = !fb_found || (cmp_ent.arrival < fb_ent.arrival) ||
                ((cmp_ent.arrival == fb_ent.arrival) && (cmp_ent.prio < fb_ent.prio));
  end

  // Found flags.
  always_ff @(posedge clk) begin
    if (rst || start) begin
      ready_found <= 1'b0;
      fb_found    <= 1'b0;
    end else if (cmp_vld && !cmp_done) begin
      if (is_ready) begin
        ready_found <= 1'b1;
      end
      fb_found <= 1'b1;
    end
  end

  // Candidate payloads.
  always_ff @(posedge clk) begin
    if (cmp_vld && is_ready && ready_better) begin
      ready_ent <= cmp_ent;
      ready_idx <= cmp_idx;
    end
    if (cmp_vld && !cmp_done && fb_better) begin
      fb_ent <= cmp_ent;
      fb_idx <= cmp_idx;
    end
  end

  assign pick = '{ready_found: ready_found, ready: ready_ent, fallback: fb_ent};

  // A ready candidate has always arrived by the current clock.
  a_ready_arrived: assert property (@(posedge clk) disable iff (rst)
    ready_found && !start |-> ({{(TimeW - ArrW){1'b0}}, ready_ent.arrival} <= clock))
    else $error("ready candidate has not arrived");

  a_fb_follows_ready: assert property (@(posedge clk) disable iff (rst)
    ready_found |-> fb_found)
    else $error("ready candidate without fallback candidate");

  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    start |=> !ready_found && !fb_found)
    else $error("scan start did not clear candidates");

endmodule

// ===== rtl/nonpreemptive_priority_scheduler.sv =====
// Top level of the non-preemptive priority scheduler: load sequencer, scan control and timing math.
//
// Input channel (in_valid/in_stall): one transaction per process with arrival, burst, prio
// and batch_end. The transaction with batch_end set, or the one that fills the MAX_PROCS-entry
// store, closes the batch.
// While a batch runs, in_stall stays high; it drops again after the last result is loaded.
// Output channel (out_valid/out_stall): one transaction per process in run order, with
// completion, turnaround and waiting times, running sums and final_result on the last one.
// For each result the sequencer scans the process memory through its single read port, one entry
// per cycle, then steps through clock, turnaround, waiting and sum arithmetic and output loading.
// Results sit in an output register; a stall holds it and the scheduler waits in its output
// state until the register is free. Synchronous reset rst empties the batch, clears the done
// flags, the clock and the sums and drops out_valid; the process memory is not cleared, since
// only entries written in the current batch are read.
module nonpreemptive_priority_scheduler #(
  parameter int MAX_PROCS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [nps_pkg::ArrW-1:0]  arrival,
  input  logic [nps_pkg::BurW-1:0]  burst,
  input  logic [nps_pkg::PriW-1:0]  prio,
  input  logic                      batch_end,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [nps_pkg::PnW-1:0]   process_number,
  output logic [nps_pkg::TimeW-1:0] completion,
  output logic [nps_pkg::TimeW-1:0] turnaround,
  output logic [nps_pkg::TimeW-1:0] waiting,
  output logic [nps_pkg::SumW-1:0]  sum_turnaround,
  output logic [nps_pkg::SumW-1:0]  sum_waiting,
  output logic                      final_result
);
  import nps_pkg::*;

  localparam int IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CW = $clog2(MAX_PROCS + 1);

  state_t state;
  state_t state_next;

  logic [CW-1:0]        count;
  logic [CW-1:0]        emitted;
  logic [CW-1:0]        scan_cnt;
  logic                 rd_vld;
  logic [IW-1:0]        rd_idx;
  logic [MAX_PROCS-1:0] done;
  logic [TimeW-1:0]     clock;
  logic [SumW-1:0]      total_turn;
  logic [SumW-1:0]      total_wait;
  logic [IW-1:0]        sel_idx;
  logic [ArrW-1:0]      sel_arr;
  logic [BurW-1:0]      sel_burst;
  logic [TimeW-1:0]     turn;
  logic [TimeW-1:0]     wait_t;

  logic                 in_acc;
  logic                 closing;
  logic                 scan_start;
  logic                 scan_issue;
  logic                 scan_last;
  logic                 out_free;
  logic                 last_result;
  logic [IW-1:0]        ram_addr;
  logic [$bits(entry_t)-1:0] ram_rdata;
  entry_t               wr_ent;
  entry_t               rd_ent;
  pick_t                pick;
  logic [IW-1:0]        ready_idx;
  logic [IW-1:0]        fb_idx;
  logic [IW:0]          pn_full;
  entry_t               chosen;
  logic [TimeW-1:0]     base;

  // Handshake and sequencing conditions.
  assign in_acc      = in_valid && !in_stall;
  assign closing     = batch_end || ((count + CW'(1)) == CW'(MAX_PROCS));
  assign scan_issue  = (state == S_SCAN) && (scan_cnt < count);
  assign scan_last   = rd_vld && ((CW'(rd_idx) + CW'(1)) == count);
  assign out_free    = !out_valid || !out_stall;
  assign last_result = (emitted + CW'(1)) == count;

  // Next state and handshake outputs.
  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    scan_start = 1'b0;
    unique case (state)
      S_LOAD: begin
        in_stall = 1'b0;
        if (in_acc && closing) begin
          state_next = S_SCAN;
          scan_start = 1'b1;
        end
      end
      S_SCAN: begin
        if (scan_last) begin
          state_next = S_CLK;
        end
      end
      S_CLK:  state_next = S_TURN;
      S_TURN: state_next = S_WAIT;
      S_WAIT: state_next = S_SUM;
      S_SUM:  state_next = S_OUT;
      S_OUT: begin
        // The candidates are cleared after every result, the last one of a batch included.
        if (out_free) begin
          scan_start = 1'b1;
          if (last_result) begin
            state_next = S_LOAD;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Process memory: written while loading, read one entry per cycle while scanning.
  assign wr_ent   = '{arrival: arrival, burst: burst, prio: prio};
  assign ram_addr = (state == S_SCAN) ? scan_cnt[IW-1:0] : count[IW-1:0];
  assign rd_ent   = entry_t'(ram_rdata);

  nps_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(MAX_PROCS)
  ) u_ram (
    .clk   (clk),
    .we    (in_acc),
    .waddr (count[IW-1:0]),
    .wdata (wr_ent),
    .raddr (ram_addr),
    .rdata (ram_rdata)
  );

  nps_select #(
    .MAX_PROCS(MAX_PROCS)
  ) u_select (
    .clk       (clk),
    .rst       (rst),
    .start     (scan_start),
    .cmp_vld   (rd_vld),
    .cmp_idx   (rd_idx),
    .cmp_ent   (rd_ent),
    .cmp_done  (done[rd_idx]),
    .clock     (clock),
    .pick      (pick),
    .ready_idx (ready_idx),
    .fb_idx    (fb_idx)
  );

  // Scan address counter and read-valid pipeline.
  always_ff @(posedge clk) begin
    if (rst || scan_start) begin
      scan_cnt <= '0;
      rd_vld   <= 1'b0;
    end else begin
      rd_vld <= scan_issue;
      if (scan_issue) begin
        scan_cnt <= scan_cnt + CW'(1);
      end
    end
    rd_idx <= scan_cnt[IW-1:0];
  end

  // Without a ready process the clock jumps to the earliest pending arrival first.
  assign chosen = pick.ready_found ? pick.ready : pick.fallback;
  assign base   = pick.ready_found ? clock : {{(TimeW - ArrW){1'b0}}, pick.fallback.arrival};

  // Batch bookkeeping: load count, done flags, clock and running sums.
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      emitted    <= '0;
      done       <= '0;
      clock      <= '0;
      total_turn <= '0;
      total_wait <= '0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (in_acc) begin
            count <= count + CW'(1);
          end
        end
        S_CLK: begin
          clock <= base + {{(TimeW - BurW){1'b0}}, chosen.burst};
        end
        S_WAIT: begin
          total_turn <= total_turn + {{(SumW - TimeW){1'b0}}, turn};
        end
        S_SUM: begin
          total_wait <= total_wait + {{(SumW - TimeW){1'b0}}, wait_t};
        end
        S_OUT: begin
          if (out_free) begin
            if (last_result) begin
              count      <= '0;
              emitted    <= '0;
              done       <= '0;
              clock      <= '0;
              total_turn <= '0;
              total_wait <= '0;
            end else begin
              emitted      <= emitted + CW'(1);
              done[sel_idx] <= 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Selected process and its turnaround and waiting times.
  always_ff @(posedge clk) begin
    if (state == S_CLK) begin
      sel_idx   <= pick.ready_found ? ready_idx : fb_idx;
      sel_arr   <= chosen.arrival;
      sel_burst <= chosen.burst;
    end
    if (state == S_TURN) begin
      turn <= clock - {{(TimeW - ArrW){1'b0}}, sel_arr};
    end
    if (state == S_WAIT) begin
      wait_t <= turn - {{(TimeW - BurW){1'b0}}, sel_burst};
    end
  end

  assign pn_full = {1'b0, sel_idx} + (IW + 1)'(1);

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_OUT) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_OUT) && out_free) begin
      process_number <= PnW'(pn_full);
      completion     <= clock;
      turnaround     <= turn;
      waiting        <= wait_t;
      sum_turnaround <= total_turn;
      sum_waiting    <= total_wait;
      final_result   <= last_result;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_PROCS))
    else $error("load count exceeds the store depth");

  a_load_done_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOAD) |-> (done == '0))
    else $error("done flags left over from a previous batch");

  a_sel_pending: assert property (@(posedge clk) disable iff (rst)
    (state == S_TURN) |-> !done[sel_idx])
    else $error("selected process is already done");

  a_emit_bound: assert property (@(posedge clk) disable iff (rst)
    (state != S_LOAD) |-> (emitted < count))
    else $error("more results than loaded processes");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) && out_valid && out_stall |=> (state == S_OUT))
    else $error("result loaded over a stalled output");

endmodule

// ===== tb/tb_nonpreemptive_priority_scheduler.sv =====
// Self-checking testbench for the non-preemptive priority scheduler with its own schedule predictor.
module tb_nonpreemptive_priority_scheduler;
  timeunit 1ns;
  timeprecision 1ps;

  import nps_pkg::*;

  localparam int MaxProcs    = 16;
  localparam int ErrPrintMax = 40;
  localparam int DrainCycles = 400;

  // One process as it is offered on the input channel.
  typedef struct {
    logic [ArrW-1:0] arrival;
    logic [BurW-1:0] burst;
    logic [PriW-1:0] prio;
    logic            batch_end;
  } proc_t;

  // One completed process as the scheduler should report it.
  typedef struct {
    logic [PnW-1:0]   proc_num;
    logic [TimeW-1:0] done_at;
    logic [TimeW-1:0] turn_time;
    logic [TimeW-1:0] wait_time;
    logic [SumW-1:0]  turn_sum;
    logic [SumW-1:0]  wait_sum;
    logic             is_last;
  } sched_result_t;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  logic [ArrW-1:0]  arrival   = '0;
  logic [BurW-1:0]  burst     = '0;
  logic [PriW-1:0]  prio      = '0;
  logic             batch_end = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [PnW-1:0]   process_number;
  logic [TimeW-1:0] completion;
  logic [TimeW-1:0] turnaround;
  logic [TimeW-1:0] waiting;
  logic [SumW-1:0]  sum_turnaround;
  logic [SumW-1:0]  sum_waiting;
  logic             final_result;

  proc_t         procs_to_load[$];
  sched_result_t sched_results_due[$];
  int            send_idle_pct = 34;
  int            recv_idle_pct = 74;
  int            error_count   = 0;
  logic          in_taken      = 1'b0;

  // Predictor copy of the process store and batch state.
  logic [ArrW-1:0] arr_mem  [MaxProcs];
  logic [BurW-1:0] bur_mem  [MaxProcs];
  logic [PriW-1:0] pri_mem  [MaxProcs];
  logic            finished [MaxProcs];
  int              loaded = 0;

  nonpreemptive_priority_scheduler #(
    .MAX_PROCS(MaxProcs)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .arrival       (arrival),
    .burst         (burst),
    .prio          (prio),
    .batch_end     (batch_end),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .process_number(process_number),
    .completion    (completion),
    .turnaround    (turnaround),
    .waiting       (waiting),
    .sum_turnaround(sum_turnaround),
    .sum_waiting   (sum_waiting),
    .final_result  (final_result)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Best process that has arrived by the given tick, or -1 when none has.
  function automatic int pick_ready(logic [TimeW-1:0] now);
    int best;
    best = -1;
    for (int i = 0; i < loaded; i++) begin
      if (!finished[i] && arr_mem[i] <= now) begin
        if (best < 0 || pri_mem[i] < pri_mem[best] ||
            (pri_mem[i] == pri_mem[best] && arr_mem[i] < arr_mem[best])) begin
          best = i;
        end
      end
    end
    return best;
  endfunction

  // Run the loaded batch to completion and queue one expected result per process.
  task automatic schedule_batch();
    logic [TimeW-1:0] now;
    logic [ArrW:0]    earliest;
    logic [SumW-1:0]  turn_acc;
    logic [SumW-1:0]  wait_acc;
    int               pick;
    sched_result_t    res;
    now      = '0;
    turn_acc = '0;
    wait_acc = '0;
    for (int i = 0; i < loaded; i++) finished[i] = 1'b0;
    for (int k = 0; k < loaded; k++) begin
      pick = pick_ready(now);
      // With nothing ready, the clock jumps to the earliest pending arrival.
      if (pick < 0) begin
        earliest = '1;
        for (int i = 0; i < loaded; i++) begin
          if (!finished[i] && arr_mem[i] < earliest) earliest = arr_mem[i];
        end
        now  = TimeW'(earliest);
        pick = pick_ready(now);
      end
      now           = now + bur_mem[pick];
      res.done_at   = now;
      res.turn_time = now - arr_mem[pick];
      res.wait_time = res.turn_time - bur_mem[pick];
      turn_acc      = turn_acc + res.turn_time;
      wait_acc      = wait_acc + res.wait_time;
      res.turn_sum  = turn_acc;
      res.wait_sum  = wait_acc;
      res.proc_num  = PnW'(pick + 1);
      res.is_last   = (k == loaded - 1);
      finished[pick] = 1'b1;
      sched_results_due.push_back(res);
    end
    loaded = 0;
  endtask

  // Store one accepted process; a batch end or a full store starts the schedule.
  task automatic load_process(proc_t p);
    arr_mem[loaded] = p.arrival;
    bur_mem[loaded] = p.burst;
    pri_mem[loaded] = p.prio;
    loaded++;
    if (p.batch_end || loaded == MaxProcs) schedule_batch();
  endtask

  task automatic flag_mismatch(string msg);
    if (error_count < ErrPrintMax) $display("MISMATCH at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) flag_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  // Input driver and receiver stall, both changed on the falling edge.
  always @(negedge clk) begin : drive_channels
    proc_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (procs_to_load.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = procs_to_load.pop_front();
        in_valid  <= 1'b1;
        arrival   <= nxt.arrival;
        burst     <= nxt.burst;
        prio      <= nxt.prio;
        batch_end <= nxt.batch_end;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Monitor: feeds accepted inputs to the predictor and checks each result transaction.
  always @(posedge clk) begin : watch_channels
    proc_t         got_in;
    sched_result_t want;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        got_in.arrival   = arrival;
        got_in.burst     = burst;
        got_in.prio      = prio;
        got_in.batch_end = batch_end;
        load_process(got_in);
      end
      if (out_valid && !out_stall) begin
        if (sched_results_due.size() == 0) begin
          flag_mismatch($sformatf("unexpected result for process %0d", process_number));
        end else begin
          want = sched_results_due.pop_front();
          check_field("process_number", process_number, want.proc_num);
          check_field("completion", completion, want.done_at);
          check_field("turnaround", turnaround, want.turn_time);
          check_field("waiting", waiting, want.wait_time);
          check_field("sum_turnaround", sum_turnaround, want.turn_sum);
          check_field("sum_waiting", sum_waiting, want.wait_sum);
          check_field("final_result", final_result, want.is_last);
        end
      end
    end
  end

  task automatic queue_proc(int arr, int bur, int pri, bit last);
    proc_t p;
    p.arrival   = ArrW'(arr);
    p.burst     = BurW'(bur);
    p.prio      = PriW'(pri);
    p.batch_end = last;
    procs_to_load.push_back(p);
  endtask

  // Tick values: some close together so processes compete, some extreme, the rest spread over the field.
  function automatic logic [15:0] pick_ticks(int spread);
    case ($urandom_range(5))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2, 3:    return 16'($urandom_range(spread));
      default: return 16'($urandom);
    endcase
  endfunction

  // Priorities: a narrow range forces ties, the rest covers the full field.
  function automatic logic [PriW-1:0] pick_prio();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      2, 3:    return PriW'($urandom_range(3));
      default: return PriW'($urandom);
    endcase
  endfunction

  // Queue whole batches of random processes until about the given count is reached.
  task automatic queue_random(int target);
    int added;
    int size;
    bit last;
    added = 0;
    while (added < target) begin
      size = ($urandom_range(3) == 0) ? $urandom_range(7, MaxProcs) : $urandom_range(1, 6);
      for (int i = 0; i < size; i++) begin
        // A full store closes the batch whatever its end flag says.
        last = (i != size - 1) ? 1'b0 : (size == MaxProcs) ? 1'($urandom_range(1)) : 1'b1;
        queue_proc(pick_ticks(60), pick_ticks(12), pick_prio(), last);
      end
      added += size;
    end
  endtask

  // Wait until every queued input transaction has been taken.
  task automatic drain_inputs();
    do @(posedge clk); while (procs_to_load.size() != 0 || in_valid);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    @(posedge clk);

    // Lone process at the top of every field: the clock must jump to its arrival.
    queue_proc(16'hFFFF, 16'hFFFF, 8'hFF, 1'b1);
    // Zero burst, equal priority and arrival settled by index, late urgent process.
    queue_proc(2, 5, 3, 1'b0);
    queue_proc(0, 0, 3, 1'b0);
    queue_proc(0, 4, 3, 1'b0);
    queue_proc(1, 16'hFFFF, 0, 1'b1);
    // Full store with no end flag, wide arrival gaps and spread priorities.
    for (int i = 0; i < MaxProcs; i++) begin
      queue_proc((i * 4097) % 65536, i * 1000 + 1, 255 - i * 17, 1'b0);
    end
    // Equal priorities and arrivals decided by index, nothing ready at tick zero.
    queue_proc(9, 1, 5, 1'b0);
    queue_proc(4, 1, 5, 1'b0);
    queue_proc(4, 1, 5, 1'b1);
    queue_random(36);
    drain_inputs();

    send_idle_pct = 74;
    recv_idle_pct = 34;
    queue_random(50);
    drain_inputs();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(50);
    drain_inputs();

    while (sched_results_due.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog for a hung handshake or missing results.
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/nps_pkg.sv
rtl/nps_ram.sv
rtl/nps_select.sv
rtl/nonpreemptive_priority_scheduler.sv
tb/tb_nonpreemptive_priority_scheduler.sv
